@@ sv/bank_switch_mapper_with_scanline_irq_defines.svh @@
`ifndef BANK_SWITCH_MAPPER_WITH_SCANLINE_IRQ_DEFINES_SVH
`define BANK_SWITCH_MAPPER_WITH_SCANLINE_IRQ_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BSM_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("bsm assertion failed");

// Next-cycle implication, checked outside reset.
`define BSM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("bsm assertion failed");

`endif

@@ sv/bsm_pkg.sv @@
`default_nettype none
package bsm_pkg;

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_TICK  = 2'd1,
        ACT_PRG   = 2'd2,
        ACT_CHR   = 2'd3
    } action_t;

    // Register decode: addr & REG_DECODE_MASK
    localparam logic [15:0] REG_DECODE_MASK = 16'hE001;
    localparam logic [15:0] REG_BANK_SELECT = 16'h8000;
    localparam logic [15:0] REG_BANK_DATA   = 16'h8001;
    localparam logic [15:0] REG_MIRROR      = 16'hA000;
    localparam logic [15:0] REG_RAM_PROTECT = 16'hA001;
    localparam logic [15:0] REG_IRQ_LATCH   = 16'hC000;
    localparam logic [15:0] REG_IRQ_RELOAD  = 16'hC001;
    localparam logic [15:0] REG_IRQ_DISABLE = 16'hE000;
    localparam logic [15:0] REG_IRQ_ENABLE  = 16'hE001;

    typedef logic [7:0][7:0] bank_file_t;

    // Entry i sits at bits [8*i +: 8]
    localparam bank_file_t BANK_RESET = {8'd1, 8'd0, 8'd7, 8'd6, 8'd5, 8'd4, 8'd2, 8'd0};

    typedef struct packed {
        action_t     action;
        logic [15:0] addr;
        logic [7:0]  wdata;
    } item_t;

    typedef struct packed {
        logic [7:0] bank_select;
        bank_file_t banks;
    } map_view_t;

    typedef struct packed {
        logic irq_line;
        logic mirror_horizontal;
        logic ram_writable;
    } levels_t;

endpackage
`default_nettype wire

@@ sv/bsm_state.sv @@
`default_nettype none
module bsm_state (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 advance,
    input  bsm_pkg::item_t      item,
    input  wire                 cfg_write,
    input  wire                 cfg_new_rev,
    output bsm_pkg::map_view_t  view,
    output bsm_pkg::levels_t    levels_next
);
    import bsm_pkg::*;

    logic [7:0] bank_select_reg, bank_select_next;
    bank_file_t banks_reg, banks_next;
    logic [7:0] mirror_reg, mirror_next;
    logic [7:0] ram_ctrl_reg, ram_ctrl_next;
    logic [7:0] counter_reg, counter_next;
    logic [7:0] latch_reg, latch_next;
    logic       reload_reg, reload_next;
    logic       enable_reg, enable_next;
    logic       asserted_reg, asserted_next;
    logic       new_rev_reg;

    always_comb begin
        bank_select_next = bank_select_reg;
        banks_next       = banks_reg;
        mirror_next      = mirror_reg;
        ram_ctrl_next    = ram_ctrl_reg;
        counter_next     = counter_reg;
        latch_next       = latch_reg;
        reload_next      = reload_reg;
        enable_next      = enable_reg;
        asserted_next    = asserted_reg;
        case (item.action)
            ACT_WRITE: begin
                case (item.addr & REG_DECODE_MASK)
                    REG_BANK_SELECT: bank_select_next = item.wdata;
                    REG_BANK_DATA:   banks_next[bank_select_reg[2:0]] = item.wdata;
                    REG_MIRROR:      mirror_next = item.wdata;
                    REG_RAM_PROTECT: ram_ctrl_next = item.wdata;
                    REG_IRQ_LATCH:   latch_next = item.wdata;
                    REG_IRQ_RELOAD:  reload_next = 1'b1;
                    REG_IRQ_DISABLE: begin
                        enable_next   = 1'b0;
                        asserted_next = 1'b0;
                    end
                    REG_IRQ_ENABLE:  enable_next = 1'b1;
                    default: ;
                endcase
            end
            ACT_TICK: begin
                // reload on zero or pending request, else count down
                if ((counter_reg == 8'd0) || reload_reg) begin
                    counter_next = latch_reg;
                    reload_next  = 1'b0;
                end else begin
                    counter_next = counter_reg - 8'd1;
                end
                if (((counter_reg != 8'd0) || new_rev_reg) && (counter_next == 8'd0)
                        && enable_reg) begin
                    asserted_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bank_select_reg <= '0;
            banks_reg       <= BANK_RESET;
            mirror_reg      <= '0;
            ram_ctrl_reg    <= '0;
            counter_reg     <= '0;
            latch_reg       <= '0;
            reload_reg      <= 1'b0;
            enable_reg      <= 1'b0;
            asserted_reg    <= 1'b0;
        end else if (advance) begin
            bank_select_reg <= bank_select_next;
            banks_reg       <= banks_next;
            mirror_reg      <= mirror_next;
            ram_ctrl_reg    <= ram_ctrl_next;
            counter_reg     <= counter_next;
            latch_reg       <= latch_next;
            reload_reg      <= reload_next;
            enable_reg      <= enable_next;
            asserted_reg    <= asserted_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            new_rev_reg <= 1'b1;
        end else if (cfg_write) begin
            new_rev_reg <= cfg_new_rev;
        end
    end

    assign view.bank_select              = bank_select_reg;
    assign view.banks                    = banks_reg;
    assign levels_next.irq_line          = asserted_next;
    assign levels_next.mirror_horizontal = mirror_next[0];
    assign levels_next.ram_writable      = ram_ctrl_next[7] & ~ram_ctrl_next[6];

endmodule
`default_nettype wire

@@ sv/bsm_lookup.sv @@
`default_nettype none
module bsm_lookup (
    input  bsm_pkg::item_t     item,
    input  bsm_pkg::map_view_t view,
    output logic [7:0]         bank
);
    import bsm_pkg::*;

    logic [1:0] prg_slot;
    logic [2:0] chr_slot;
    logic [7:0] prg_bank;
    logic [7:0] chr_bank;
    logic [7:0] chr_pair;

    always_comb begin
        // program: swap mode exchanges the two lower-even windows
        prg_slot = item.addr[14:13];
        if (!prg_slot[0] && view.bank_select[6]) begin
            prg_slot[1] = ~prg_slot[1];
        end
        if (prg_slot[1]) begin
            prg_bank = {7'h3F, prg_slot[0]};
        end else begin
            prg_bank = {1'b0, view.banks[{2'b11, prg_slot[0]}][6:0]};
        end

        // character: inversion swaps the 2 KiB and 1 KiB halves
        chr_slot = item.addr[12:10];
        if (view.bank_select[7]) begin
            chr_slot[2] = ~chr_slot[2];
        end
        chr_pair = view.banks[{2'b00, chr_slot[1]}];
        if (chr_slot[2]) begin
            chr_bank = view.banks[chr_slot - 3'd2];
        end else begin
            chr_bank = {chr_pair[7:1], chr_slot[0]};
        end

        case (item.action)
            ACT_PRG: bank = prg_bank;
            ACT_CHR: bank = chr_bank;
            default: bank = 8'd0;
        endcase
    end

endmodule
`default_nettype wire

@@ sv/bank_switch_mapper_with_scanline_irq.sv @@
// Channel | Direction | Handshake              | Payload
// s_      | in        | s_valid / s_ready      | s_action, s_addr, s_wdata
// m_      | out       | m_valid / m_ready      | m_bank, m_irq_line, m_mirror_horizontal,
//         |           |                        | m_ram_writable
// cfg_    | in        | cfg_valid / cfg_ready  | cfg_data (new_revision_irq)
//
// From s_ accept to m_valid: the accept edge loads the input register, then the result
// register loads when it is free or being drained, after one pass of decode, lookup
// and the 8-bit counter step.
// One item is taken per cycle while m_ready stays high; the single result register
// sets that figure.
// Reset (aresetn low, synchronous) empties both stages and loads the bank registers
// with their power-up values; new_revision_irq resets to 1.
// A stall on m_ready holds the result and the pending item; s_ready drops only
// when both stages are full.
`default_nettype none
module bank_switch_mapper_with_scanline_irq (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        s_valid,
    output logic       s_ready,
    input  wire [1:0]  s_action,
    input  wire [15:0] s_addr,
    input  wire [7:0]  s_wdata,
    output logic       m_valid,
    input  wire        m_ready,
    output logic [7:0] m_bank,
    output logic       m_irq_line,
    output logic       m_mirror_horizontal,
    output logic       m_ram_writable,
    input  wire        cfg_valid,
    output logic       cfg_ready,
    input  wire        cfg_data
);
    import bsm_pkg::*;

    item_t      in_item_reg;
    logic       in_valid_reg;
    logic       m_valid_reg;
    logic [7:0] m_bank_reg;
    levels_t    m_levels_reg;

    logic       out_free;
    logic       advance;
    map_view_t  view;
    levels_t    levels_next;
    logic [7:0] bank;

    // advance the held item when the result register is empty or being drained
    assign out_free  = ~m_valid_reg | m_ready;
    assign advance   = in_valid_reg & out_free;
    assign s_ready   = ~in_valid_reg | advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    // hold payload until the stage moves on
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_item_reg.action <= action_t'(s_action);
            in_item_reg.addr   <= s_addr;
            in_item_reg.wdata  <= s_wdata;
        end
    end

    bsm_state u_state (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (advance),
        .item        (in_item_reg),
        .cfg_write   (cfg_valid),
        .cfg_new_rev (cfg_data),
        .view        (view),
        .levels_next (levels_next)
    );

    // lookups read state as left by all earlier items
    bsm_lookup u_lookup (
        .item (in_item_reg),
        .view (view),
        .bank (bank)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_bank_reg   <= bank;
            m_levels_reg <= levels_next;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_bank              = m_bank_reg;
    assign m_irq_line          = m_levels_reg.irq_line;
    assign m_mirror_horizontal = m_levels_reg.mirror_horizontal;
    assign m_ram_writable      = m_levels_reg.ram_writable;

endmodule
`default_nettype wire

@@ sv/bsm_checker.sv @@
`default_nettype none
`include "bank_switch_mapper_with_scanline_irq_defines.svh"
module bsm_checker (
    input wire       aclk,
    input wire       aresetn,
    input wire       s_ready,
    input wire       m_valid,
    input wire       m_ready,
    input wire [7:0] m_bank,
    input wire       m_irq_line
);
    // a free result slot always lets a new item in
    `BSM_ASSERT_NOW(a_ready_when_free, aclk, aresetn, (!m_valid || m_ready), s_ready)
    // the result stage comes out of reset empty
    `BSM_ASSERT_NOW(a_empty_after_reset, aclk, aresetn, $past(!aresetn), !m_valid)
    // a stalled result holds
    `BSM_ASSERT_NEXT(a_stall_holds, aclk, aresetn, (m_valid && !m_ready),
        (m_valid && $stable(m_bank) && $stable(m_irq_line)))
endmodule

bind bank_switch_mapper_with_scanline_irq bsm_checker u_bsm_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_bank     (m_bank),
    .m_irq_line (m_irq_line)
);
`default_nettype wire
